>>> sv/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEPTH  = 32;
   localparam int WORD_W = 32;
   localparam int ACT_W  = 3;
   localparam int ST_W   = 2;
   localparam int OCC_W  = $clog2(DEPTH + 1);

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [ACT_W-1:0]         action_type;
   typedef logic [ST_W-1:0]          status_type;
   typedef logic [OCC_W-1:0]         occ_type;

   localparam action_type ACT_PUSH_FRONT = 3'd0;
   localparam action_type ACT_PUSH_BACK  = 3'd1;
   localparam action_type ACT_POP_FRONT  = 3'd2;
   localparam action_type ACT_POP_BACK   = 3'd3;
   localparam action_type ACT_SHOW       = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      word_type    word;
   } cell_cmd_type;

endpackage

>>> sv/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  deq_pkg::cell_cmd_type cmd,
   input  deq_pkg::word_type    left_data,
   input  logic                 left_valid,
   input  deq_pkg::word_type    right_data,
   input  logic                 right_valid,
   input  deq_pkg::word_type    head_data,
   output deq_pkg::word_type    data,
   output logic                 valid
);
   import deq_pkg::*;

   word_type data_ff, data_in;
   logic     valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (cmd.op)
         OP_PUSH_FRONT: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         OP_POP_FRONT: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         OP_PUSH_BACK: begin
            if (!valid_ff && left_valid) begin
               data_in  = cmd.word;
               valid_in = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         OP_ROTATE: begin
            // last occupied cell takes the head word
            if (valid_ff) begin
               data_in = right_valid ? right_data : head_data;
            end
         end
         default: begin
            data_in  = data_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

>>> sv/deq_chain.sv
`timescale 1ns / 1ps

module deq_chain (
   input  logic                 clock,
   input  logic                 reset,
   input  deq_pkg::cell_cmd_type cmd,
   output deq_pkg::word_type    front_data,
   output deq_pkg::word_type    back_data,
   output logic                 full,
   output logic                 empty
);
   import deq_pkg::*;

   word_type             cell_data  [DEPTH];
   logic     [DEPTH-1:0] cell_valid;
   word_type             left_data  [DEPTH];
   word_type             right_data [DEPTH];
   logic     [DEPTH-1:0] left_valid;
   logic     [DEPTH-1:0] right_valid;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) begin
            left_data[i]  = cmd.word;
            left_valid[i] = 1'b1;
         end else begin
            left_data[i]  = cell_data[i-1];
            left_valid[i] = cell_valid[i-1];
         end
         if (i == DEPTH - 1) begin
            right_data[i]  = '0;
            right_valid[i] = 1'b0;
         end else begin
            right_data[i]  = cell_data[i+1];
            right_valid[i] = cell_valid[i+1];
         end
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_data   (left_data[g]),
         .left_valid  (left_valid[g]),
         .right_data  (right_data[g]),
         .right_valid (right_valid[g]),
         .head_data   (cell_data[0]),
         .data        (cell_data[g]),
         .valid       (cell_valid[g])
      );
   end

   // back word: the one occupied cell whose right neighbor is empty
   always_comb begin
      back_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_valid[i] && !right_valid[i]) begin
            back_data = back_data | cell_data[i];
         end
      end
   end

   assign front_data = cell_data[0];
   assign full       = cell_valid[DEPTH-1];
   assign empty      = !cell_valid[0];

endmodule

>>> sv/double_ended_queue.sv
`timescale 1ns / 1ps
// A result word is registered and shows in the cycle after its request is accepted.
// Push and pop requests are taken at one request per cycle while rsp_ready holds.
// Show gives one response word per element (a single one if empty); the cell row rotates one place per
// element, and no request is taken until the last element has gone out.
// Reset (synchronous, active high) empties the queue; stored words are not cleared.

module double_ended_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  deq_pkg::action_type  req_action,
   input  deq_pkg::word_type    req_value_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output deq_pkg::word_type    rsp_value_out,
   output deq_pkg::status_type  rsp_status,
   output logic                 rsp_is_last
);
   import deq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SHOW
   } state_type;

   state_type    state_ff;
   occ_type      occ_ff;
   occ_type      cnt_ff;
   logic         rsp_valid_ff;
   word_type     rsp_value_ff;
   status_type   rsp_status_ff;
   logic         rsp_last_ff;

   cell_cmd_type cmd;
   word_type     front_data;
   word_type     back_data;
   logic         chain_full;
   logic         chain_empty;
   logic         out_free;
   logic         req_fire;
   logic         show_step;
   logic         show_last;

   deq_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .front_data (front_data),
      .back_data  (back_data),
      .full       (chain_full),
      .empty      (chain_empty)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign show_step = (state_ff == S_SHOW) && out_free;
   assign show_last = (cnt_ff == occ_type'(occ_ff - occ_type'(1)));

   always_comb begin
      cmd.op   = OP_HOLD;
      cmd.word = req_value_in;
      if (req_fire) begin
         case (req_action)
            ACT_PUSH_FRONT: if (!chain_full)  cmd.op = OP_PUSH_FRONT;
            ACT_PUSH_BACK:  if (!chain_full)  cmd.op = OP_PUSH_BACK;
            ACT_POP_FRONT:  if (!chain_empty) cmd.op = OP_POP_FRONT;
            ACT_POP_BACK:   if (!chain_empty) cmd.op = OP_POP_BACK;
            ACT_SHOW:       if (!chain_empty) cmd.op = OP_ROTATE;
            default:        cmd.op = OP_HOLD;
         endcase
      end else if (show_step) begin
         cmd.op = OP_ROTATE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_value_ff  <= '0;
         rsp_status_ff <= ST_OK;
         rsp_last_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            case (req_action)
               ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= '0;
                  rsp_status_ff <= chain_full ? ST_FULL : ST_OK;
                  rsp_last_ff   <= 1'b1;
                  if (!chain_full) begin
                     occ_ff <= occ_type'(occ_ff + occ_type'(1));
                  end
               end
               ACT_POP_FRONT, ACT_POP_BACK: begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= chain_empty ? ST_EMPTY : ST_OK;
                  rsp_last_ff   <= 1'b1;
                  if (chain_empty) begin
                     rsp_value_ff <= '0;
                  end else begin
                     rsp_value_ff <= (req_action == ACT_POP_FRONT) ? front_data : back_data;
                     occ_ff       <= occ_type'(occ_ff - occ_type'(1));
                  end
               end
               ACT_SHOW: begin
                  rsp_valid_ff <= 1'b1;
                  if (chain_empty) begin
                     rsp_value_ff  <= '0;
                     rsp_status_ff <= ST_EMPTY;
                     rsp_last_ff   <= 1'b1;
                  end else begin
                     rsp_value_ff  <= front_data;
                     rsp_status_ff <= ST_OK;
                     rsp_last_ff   <= (occ_ff == occ_type'(1));
                     if (occ_ff != occ_type'(1)) begin
                        state_ff <= S_SHOW;
                        cnt_ff   <= occ_type'(1);
                     end
                  end
               end
               default: begin
                  // out_free held, so any pending word left at this edge
                  rsp_valid_ff <= 1'b0;
               end
            endcase
         end else if (show_step) begin
            rsp_valid_ff  <= 1'b1;
            rsp_value_ff  <= front_data;
            rsp_status_ff <= ST_OK;
            rsp_last_ff   <= show_last;
            cnt_ff        <= occ_type'(cnt_ff + occ_type'(1));
            if (show_last) begin
               state_ff <= S_IDLE;
            end
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_is_last   = rsp_last_ff;

`ifndef SYNTH
   a_occ_matches_cells: assert property (@(posedge clock) disable iff (reset)
      ((occ_ff == '0) == chain_empty) && ((occ_ff == occ_type'(DEPTH)) == chain_full))
      else $error("occupancy disagrees with cell valid bits");

   a_show_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHOW) |-> (cnt_ff != '0) && (cnt_ff < occ_ff))
      else $error("show counter out of range");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (occ_ff == $past(occ_ff)) || (occ_ff == occ_type'($past(occ_ff) + 1'b1))
               || (occ_ff == occ_type'($past(occ_ff) - 1'b1)))
      else $error("occupancy moved by more than one");
`endif

endmodule
